FILE: sv/utf8d_pkg.sv
package utf8d_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CpW   = 31;
   localparam int unsigned PendW = 3;
   localparam int unsigned ContW = 6;

   localparam logic [PendW-1:0] PendNone = '0;

   typedef struct packed {
      logic            vld;
      logic [CpW-1:0]  cp;
      logic            err;
      logic            done;
   } res_type;

endpackage

FILE: sv/utf8d_step.sv
module utf8d_step import utf8d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [ByteW-1:0] byte_in,
   input  logic             last_byte,
   output res_type          res
);

   logic [PendW-1:0] pend_ff, pend_in;
   logic [CpW-1:0]   part_ff, part_in;

   logic [PendW-1:0] need;
   logic [CpW-1:0]   payload;
   logic             lead_ok;
   logic [CpW-1:0]   cont_val;
   logic [PendW-1:0] pend_dec;

   always_comb begin
      need    = PendNone;
      payload = '0;
      lead_ok = 1'b1;
      if ((byte_in & 8'hE0) == 8'hC0) begin
         need    = 3'd1;
         payload = CpW'(byte_in[4:0]);
      end else if ((byte_in & 8'hF0) == 8'hE0) begin
         need    = 3'd2;
         payload = CpW'(byte_in[3:0]);
      end else if ((byte_in & 8'hF8) == 8'hF0) begin
         need    = 3'd3;
         payload = CpW'(byte_in[2:0]);
      end else if ((byte_in & 8'hFC) == 8'hF8) begin
         need    = 3'd4;
         payload = CpW'(byte_in[1:0]);
      end else if ((byte_in & 8'hFE) == 8'hFC) begin
         need    = 3'd5;
         payload = CpW'(byte_in[0]);
      end else begin
         lead_ok = 1'b0;
      end
   end

   assign cont_val = {part_ff[CpW-ContW-1:0], byte_in[ContW-1:0]};
   assign pend_dec = pend_ff - 3'd1;

   always_comb begin
      pend_in  = pend_ff;
      part_in  = part_ff;
      res.vld  = 1'b0;
      res.cp   = '0;
      res.err  = 1'b0;
      res.done = last_byte;
      if (go) begin
         if (pend_ff == PendNone) begin
            if (!byte_in[ByteW-1]) begin
               res.vld = 1'b1;
               res.cp  = CpW'(byte_in);
            end else if (!lead_ok || last_byte) begin
               res.vld = 1'b1;
               res.err = 1'b1;
               part_in = '0;
            end else begin
               pend_in = need;
               part_in = payload;
            end
         end else begin
            pend_in = pend_dec;
            part_in = cont_val;
            if (pend_dec == PendNone) begin
               res.vld = 1'b1;
               res.cp  = cont_val;
               part_in = '0;
            end else if (last_byte) begin
               res.vld = 1'b1;
               res.err = 1'b1;
               pend_in = PendNone;
               part_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PendNone;
         part_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         part_ff <= part_in;
      end
   end

endmodule

FILE: sv/utf8_stream_decoder.sv
// Path: an accepted input item is held in the input register, then passes the
// single-pass decode step into the result register; a stalled result register holds it back.
// Throughput: one byte per cycle; a new item is taken every cycle the result side drains.
// Reset: synchronous, active high; clears valid flags and the pending sequence state.
module utf8_stream_decoder import utf8d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] code_point, [31] zero
   output logic        rsp_tuser,   // decode_error
   output logic        rsp_tlast    // buffer_done
);

   logic             s1_vld_ff, s1_vld_in;
   logic [ByteW-1:0] s1_byte_ff;
   logic             s1_last_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [CpW-1:0]   rsp_cp_ff;
   logic             rsp_err_ff;
   logic             rsp_done_ff;
   logic             out_free;
   logic             step_go;
   res_type          res;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign step_go    = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || out_free;
   assign s1_vld_in  = req_tready ? req_tvalid : s1_vld_ff;
   assign rsp_vld_in = out_free ? res.vld : rsp_vld_ff;

   utf8d_step u_step (
      .clock     (clock),
      .reset     (reset),
      .go        (step_go),
      .byte_in   (s1_byte_ff),
      .last_byte (s1_last_ff),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (res.vld && out_free) begin
         rsp_cp_ff   <= res.cp;
         rsp_err_ff  <= res.err;
         rsp_done_ff <= res.done;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_cp_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

FILE: tb/sv/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
   import utf8d_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned ItemTarget = 1950;
   localparam int unsigned MaxShown   = 10;

   typedef struct packed {
      logic [ByteW-1:0] b;
      logic             last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   byte_item_type    byte_q[$];
   res_type          cp_expect_q[$];
   logic [PendW-1:0] pend_cnt = PendNone;
   logic [CpW-1:0]   part_val = '0;
   int unsigned      mismatches = 0;
   int unsigned      bytes_taken = 0;
   int unsigned      hold_cnt = 0;
   int unsigned      hold_idx = 0;
   logic [31:0]      cycle_cnt = '0;
   int unsigned      gap_left = 0;
   int unsigned      stall_left = 0;
   logic             calm;

   // quiet windows in which no new random idling starts on either side
   assign calm = (cycle_cnt[10:9] == 2'b00);

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      else if (roll < 95) return $urandom_range(4, 8);
      else return $urandom_range(20, 60);
   endfunction

   task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
      res_type          r;
      logic [PendW-1:0] need;
      logic [CpW-1:0]   pay;
      r = '0;
      need = PendNone;
      pay = '0;
      if (pend_cnt == PendNone) begin
         if (!b[ByteW-1]) begin
            r.vld = 1'b1;
            r.cp = CpW'(b);
            r.done = last;
         end else if ((b & 8'hE0) == 8'hC0) begin
            need = PendW'(1); pay = CpW'(b[4:0]);
         end else if ((b & 8'hF0) == 8'hE0) begin
            need = PendW'(2); pay = CpW'(b[3:0]);
         end else if ((b & 8'hF8) == 8'hF0) begin
            need = PendW'(3); pay = CpW'(b[2:0]);
         end else if ((b & 8'hFC) == 8'hF8) begin
            need = PendW'(4); pay = CpW'(b[1:0]);
         end else if ((b & 8'hFE) == 8'hFC) begin
            need = PendW'(5); pay = CpW'(b[0]);
         end else begin
            r.vld = 1'b1;
            r.err = 1'b1;
            r.done = last;
         end
         if (need != PendNone) begin
            if (last) begin
               r.vld = 1'b1;
               r.err = 1'b1;
               r.done = 1'b1;
            end else begin
               pend_cnt = need;
               part_val = pay;
            end
         end
      end else begin
         part_val = (part_val << ContW) | CpW'(b[ContW-1:0]);
         pend_cnt = pend_cnt - 1'b1;
         if (pend_cnt == PendNone) begin
            r.vld = 1'b1;
            r.cp = part_val;
            r.done = last;
         end else if (last) begin
            r.vld = 1'b1;
            r.err = 1'b1;
            r.done = 1'b1;
         end
      end
      if (r.vld) begin
         pend_cnt = PendNone;
         part_val = '0;
         cp_expect_q.push_back(r);
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxShown) $display("mismatch: %s", msg);
   endtask

   task automatic add_byte(input logic [ByteW-1:0] b, input logic last);
      byte_item_type it;
      it.b = b;
      it.last = last;
      byte_q.push_back(it);
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("utf8_stream_decoder test failed");
         $finish;
      end
   end

   // long receiver hold-offs so the decoder backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if ((hold_idx == 0 && bytes_taken >= 300) ||
                   (hold_idx == 1 && bytes_taken >= 1200)) begin
         hold_cnt <= 400;
         hold_idx <= hold_idx + 1;
      end
   end

   always @(posedge clock) begin
      byte_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
               nxt = byte_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.b;
               req_tlast <= nxt.last;
               if (!calm && $urandom_range(0, 2) == 0) gap_left = idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cp_expect_q.size() == 0) begin
               note_mismatch($sformatf("unexpected item data=%h err=%b done=%b",
                                       rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = cp_expect_q.pop_front();
               if (rsp_tdata !== {1'b0, want.cp} || rsp_tuser !== want.err ||
                   rsp_tlast !== want.done)
                  note_mismatch($sformatf(
                     "expected cp=%h err=%b done=%b, got data=%h err=%b done=%b",
                     want.cp, want.err, want.done, rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_cnt != 0) begin
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned      roll;
      int unsigned      len;
      int unsigned      cut;
      logic             end_buf;
      logic [31:0]      rnd;
      logic [ByteW-1:0] lead;
      logic [ByteW-1:0] b;

      // directed: ASCII limits, each lead form, bad leads, truncation
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b1);
      add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0);
      add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
      add_byte(8'hF8, 1'b0); add_byte(8'h88, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'hFD, 1'b0);
      repeat (5) add_byte(8'hBF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
      add_byte(8'hC3, 1'b1);

      while (byte_q.size() < ItemTarget) begin
         roll = $urandom_range(0, 99);
         rnd = $urandom;
         if (roll < 80) begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
            case (len)
               1: lead = {1'b0, rnd[6:0]};
               2: lead = {3'b110, rnd[4:0]};
               3: lead = {4'b1110, rnd[3:0]};
               4: lead = {5'b11110, rnd[2:0]};
               5: lead = {6'b111110, rnd[1:0]};
               default: lead = {7'b1111110, rnd[0]};
            endcase
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : 0;
            end_buf = ($urandom_range(0, 9) == 0);
            for (int k = 1; k <= len; k++) begin
               rnd = $urandom;
               if (k == 1) b = lead;
               else if ($urandom_range(0, 9) == 0) b = rnd[7:0];
               else b = {2'b10, rnd[5:0]};
               if (cut != 0 && k == cut && k < len) begin
                  add_byte(b, 1'b1);
                  break;
               end
               add_byte(b, (k == len) && end_buf);
            end
         end else begin
            case ($urandom_range(0, 3))
               0: b = 8'hFE;
               1: b = 8'hFF;
               2: b = {2'b10, rnd[5:0]};
               default: b = rnd[7:0];
            endcase
            add_byte(b, $urandom_range(0, 6) == 0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_tvalid) @(posedge clock);
      while (cp_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && cp_expect_q.size() == 0) begin
         $display("utf8_stream_decoder test passed");
      end else begin
         $display("utf8_stream_decoder test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_test.sv
